@@ src/spe_pkg.sv @@
// Shared constants, types and field layouts for the SPI slave packet exchange block.
package spe_pkg;

  // Packet geometry
  localparam int unsigned PacketBytes = 7;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned SumBytes    = PacketBytes - 1;

  // Header bytes
  localparam logic [7:0] HdrIn  = 8'h55;
  localparam logic [7:0] HdrOut = 8'hAA;

  // Operation codes carried in the input tuser
  localparam logic OpCsSample = 1'b0;
  localparam logic OpRxByte   = 1'b1;

  // Channel widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 56;

  typedef logic [PacketBytes-1:0][7:0] pkt_bytes_t;
  typedef logic [SumBytes-1:0][7:0]    rx_bytes_t;

  // One accepted input item
  typedef struct packed {
    logic        op;
    logic        cs_level;
    logic [7:0]  rx_byte;
    logic [15:0] motor_rpm;
    logic [7:0]  vehicle_speed;
    logic [1:0]  switch_mode;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic               tx_load;
    logic [7:0]         tx_byte;
    logic               packet_done;
    logic               packet_valid;
    logic signed [15:0] power_watts;
    logic [7:0]         ok_to_start;
    logic [7:0]         charge_percent;
    logic [7:0]         temp_raw;
  } result_t;

endpackage

@@ src/spi_slave_packet_exchange_top.sv @@
// Top level of the SPI slave packet exchange: input stage, core and result register.
//
//  channel | dir | tdata (low bit up)                            | tuser     | tlast
//  s_axis  | in  | cs_level, rx_byte, motor_rpm, vehicle_speed,  | operation | -
//          |     | switch_mode, zero fill to 40 bits             |           |
//  m_axis  | out | tx_load, tx_byte, packet_valid, power_watts,  | -         | packet_done
//          |     | ok_to_start, charge_percent, temp_raw,        |           |
//          |     | zero fill to 56 bits                          |           |
//
// Each item passes through the input register, then through the core into the
// result register. One item per cycle is sustained while m_axis_tready_i is
// high. Reset clears the exchange state (index, heartbeat, reply bytes, latched
// values) and sets the last chip select high. A stall on m_axis holds the result
// register and, once the input register is also full, drops s_axis_tready_o.
module spi_slave_packet_exchange_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // cs_level, rx_byte, motor_rpm, vehicle_speed, switch_mode
  input  logic [spe_pkg::InDataW-1:0]  s_axis_tdata_i,
  // operation
  input  logic [spe_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tx_load, tx_byte, packet_valid, power_watts, ok_to_start, charge_percent,
  // temp_raw
  output logic [spe_pkg::OutDataW-1:0] m_axis_tdata_o,
  // packet_done
  output logic                         m_axis_tlast_o
);

  logic              in_valid_q;
  spe_pkg::in_item_t in_item_q, in_item;
  logic              out_valid_q;
  spe_pkg::result_t  res_q, res;
  logic              advance;

  // Unpack the input transfer
  assign in_item = '{
    op:            s_axis_tuser_i[0],
    cs_level:      s_axis_tdata_i[0],
    rx_byte:       s_axis_tdata_i[8:1],
    motor_rpm:     s_axis_tdata_i[24:9],
    vehicle_speed: s_axis_tdata_i[32:25],
    switch_mode:   s_axis_tdata_i[34:33]
  };

  // Core steps when the result register is free
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= in_item;
    end
  end

  spe_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_q.packet_done;
  assign m_axis_tdata_o  = {6'b0, res_q.temp_raw, res_q.charge_percent, res_q.ok_to_start,
                            res_q.power_watts, res_q.packet_valid,
                            res_q.tx_byte, res_q.tx_load};

endmodule

@@ src/spe_reply.sv @@
// Reply packet builder: header, heartbeat, rpm, speed, mode and additive checksum.
module spe_reply (
  input  logic [7:0]          heartbeat_i,
  input  logic [15:0]         motor_rpm_i,
  input  logic [7:0]          vehicle_speed_i,
  input  logic [1:0]          switch_mode_i,
  output spe_pkg::pkt_bytes_t reply_o
);

  logic [7:0] csum;

  // Payload bytes
  always_comb begin
    reply_o    = '0;
    reply_o[0] = spe_pkg::HdrOut;
    reply_o[1] = heartbeat_i;
    reply_o[2] = motor_rpm_i[15:8];
    reply_o[3] = motor_rpm_i[7:0];
    reply_o[4] = vehicle_speed_i;
    reply_o[5] = {6'b0, switch_mode_i};
    reply_o[6] = csum;
  end

  // 8-bit wrapping sum of the first six bytes
  assign csum = spe_pkg::HdrOut + heartbeat_i + motor_rpm_i[15:8] + motor_rpm_i[7:0]
              + vehicle_speed_i + {6'b0, switch_mode_i};

endmodule

@@ src/spe_core.sv @@
// Exchange state and per-item processing: chip-select edge, byte store, packet check.
module spe_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  spe_pkg::in_item_t item_i,
  output spe_pkg::result_t  res_o
);

  localparam logic [spe_pkg::IdxW-1:0] LastIdx = spe_pkg::IdxW'(spe_pkg::PacketBytes - 1);
  localparam logic [spe_pkg::IdxW-1:0] EndIdx  = spe_pkg::IdxW'(spe_pkg::PacketBytes);

  logic [spe_pkg::IdxW-1:0] idx_q, idx_d, idx_inc;
  logic                     last_cs_q, last_cs_d;
  logic [7:0]               hb_q, hb_d, hb_inc;
  spe_pkg::pkt_bytes_t      tx_q, tx_d, reply;
  spe_pkg::rx_bytes_t       rx_q;
  logic signed [15:0]       power_q, power_d;
  logic [7:0]               ok_q, ok_d, charge_q, charge_d, temp_q, temp_d;
  logic [7:0]               rx_sum;
  logic                     rx_wr;
  logic                     load, done, valid;
  logic [7:0]               txb;

  assign hb_inc  = hb_q + 8'd1;
  assign idx_inc = idx_q + spe_pkg::IdxW'(1);

  // Reply built with the incremented heartbeat
  spe_reply u_reply (
    .heartbeat_i     (hb_inc),
    .motor_rpm_i     (item_i.motor_rpm),
    .vehicle_speed_i (item_i.vehicle_speed),
    .switch_mode_i   (item_i.switch_mode),
    .reply_o         (reply)
  );

  // Checksum over the stored bytes of the incoming packet
  always_comb begin
    rx_sum = '0;
    for (int i = 0; i < spe_pkg::SumBytes; i++) begin
      rx_sum = rx_sum + rx_q[i];
    end
  end

  // Next state and result
  always_comb begin
    idx_d     = idx_q;
    last_cs_d = last_cs_q;
    hb_d      = hb_q;
    tx_d      = tx_q;
    power_d   = power_q;
    ok_d      = ok_q;
    charge_d  = charge_q;
    temp_d    = temp_q;
    rx_wr     = 1'b0;
    load      = 1'b0;
    txb       = '0;
    done      = 1'b0;
    valid     = 1'b0;
    unique case (item_i.op)
      spe_pkg::OpCsSample: begin
        last_cs_d = item_i.cs_level;
        // falling edge of chip select starts a transaction
        if (last_cs_q && !item_i.cs_level) begin
          idx_d = '0;
          hb_d  = hb_inc;
          tx_d  = reply;
          load  = 1'b1;
          txb   = reply[0];
        end
      end
      spe_pkg::OpRxByte: begin
        if (idx_q < EndIdx) begin
          if (idx_q != LastIdx) begin
            rx_wr = 1'b1;
            idx_d = idx_inc;
            load  = 1'b1;
            txb   = tx_q[idx_inc];
          end else begin
            // final byte: check header and checksum, then rebuild the reply
            done = 1'b1;
            if (rx_q[0] == spe_pkg::HdrIn && rx_sum == item_i.rx_byte) begin
              valid    = 1'b1;
              power_d  = {rx_q[1], rx_q[2]};
              ok_d     = rx_q[3];
              charge_d = rx_q[4];
              temp_d   = rx_q[5];
            end
            idx_d = '0;
            hb_d  = hb_inc;
            tx_d  = reply;
            load  = 1'b1;
            txb   = reply[0];
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o = '{
    tx_load:        load,
    tx_byte:        txb,
    packet_done:    done,
    packet_valid:   valid,
    power_watts:    power_d,
    ok_to_start:    ok_d,
    charge_percent: charge_d,
    temp_raw:       temp_d
  };

  // Control and reply state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      last_cs_q <= 1'b1;
      hb_q      <= '0;
      tx_q      <= '0;
      power_q   <= '0;
      ok_q      <= '0;
      charge_q  <= '0;
      temp_q    <= '0;
    end else if (en_i) begin
      idx_q     <= idx_d;
      last_cs_q <= last_cs_d;
      hb_q      <= hb_d;
      tx_q      <= tx_d;
      power_q   <= power_d;
      ok_q      <= ok_d;
      charge_q  <= charge_d;
      temp_q    <= temp_d;
    end
  end

  // Received bytes, no reset needed
  always_ff @(posedge clk_i) begin
    if (en_i && rx_wr) begin
      rx_q[idx_q] <= item_i.rx_byte;
    end
  end

endmodule
